>>> rtl/otll_pkg.sv
// Shared types, codes and helpers of the object text line loader.
package otll_pkg;

  // Fixed column layout of one listing line
  localparam int unsigned LineCols     = 29;
  localparam int unsigned PipeCol      = 28;
  localparam int unsigned DataCol      = 7;
  localparam int unsigned LastBlankCol = 27;
  localparam int unsigned MaxBytes     = 10;
  localparam int unsigned ColW         = 5;
  localparam int unsigned NbyteW       = 4;

  // Line queue between classifier and emitter
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  // Input actions
  localparam logic [1:0] ACT_CHAR = 2'd0;
  localparam logic [1:0] ACT_EOL  = 2'd1;
  localparam logic [1:0] ACT_EOF  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_WRITE     = 3'd0;
  localparam logic [2:0] KIND_LINE_OK   = 3'd1;
  localparam logic [2:0] KIND_LINE_BAD  = 3'd2;
  localparam logic [2:0] KIND_LOAD_OK   = 3'd3;
  localparam logic [2:0] KIND_LOAD_FAIL = 3'd4;

  // Characters with a fixed role
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef logic [NbyteW-1:0] nbyte_t;

  // One classified request for the back end: an optional burst of writes, then a status
  typedef struct packed {
    logic [2:0]                 kind;
    logic [11:0]                addr;
    nbyte_t                     nbytes;
    logic [MaxBytes-1:0][7:0]   data;
    logic [15:0]                line;
  } line_entry_t;

  // Decode one hex digit: bit 4 flags a valid digit, bits 3:0 give its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

>>> rtl/otll_front.sv
// Front end: takes characters, checks each line column by column, queues verdicts.
module otll_front #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [7:0]           char_code_i,
  output logic                 push_o,
  output otll_pkg::line_entry_t entry_o,
  input  logic                 full_i
);
  import otll_pkg::*;

  logic [ColW-1:0]  col_q, col_d;
  logic             blank_q, blank_d;
  logic             hdr_bad_q, hdr_bad_d;
  logic [11:0]      addr_q, addr_d;
  logic             run_q, run_d;
  logic             c7_blank_q, c7_blank_d;
  logic             pair_bad_q, pair_bad_d;
  logic             trail_bad_q, trail_bad_d;
  logic             tail8_bad_q, tail8_bad_d;
  logic             pipe_ok_q, pipe_ok_d;
  nbyte_t           n_q, n_d;
  logic [3:0]       hi_q, hi_d;
  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [11:0]      prior_q, prior_d;
  logic             prior_valid_q, prior_valid_d;
  logic             failed_q, failed_d;
  logic [15:0]      line_cnt_q, line_cnt_d;

  logic        accept;
  logic [4:0]  hex;
  logic        is_hex;
  logic        is_space;
  logic        odd_col;
  logic [12:0] last_addr;
  logic        full_line;
  logic        addr_above;
  logic        in_range;
  logic        line_ok;
  logic        data_line;
  logic [15:0] line_next;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;

  assign hex      = hex_decode(char_code_i);
  assign is_hex   = hex[4];
  assign is_space = (char_code_i == CH_SPACE);
  assign odd_col  = col_q[0];

  // Verdict of the line held so far
  assign last_addr  = 13'(addr_q) + 13'(n_q) - 13'd1;
  assign full_line  = (col_q == ColW'(LineCols)) && pipe_ok_q;
  assign addr_above = !prior_valid_q || (addr_q > prior_q);
  assign in_range   = 14'(last_addr) < 14'(MEM_BYTES);
  assign line_next  = (line_cnt_q == 16'hFFFF) ? line_cnt_q : line_cnt_q + 16'd1;

  always_comb begin
    line_ok   = 1'b0;
    data_line = 1'b0;
    if (!full_line) begin
      line_ok = 1'b0;
    end else if (blank_q) begin
      line_ok = 1'b1;
    end else if (hdr_bad_q) begin
      line_ok = 1'b0;
    end else if (c7_blank_q) begin
      line_ok = !tail8_bad_q;
    end else begin
      data_line = 1'b1;
      line_ok   = addr_above && !pair_bad_q && !trail_bad_q && in_range;
    end
  end

  // Build the queued request
  always_comb begin
    entry_o        = '0;
    entry_o.data   = bytes_q;
    entry_o.addr   = addr_q;
    if (action_i == ACT_EOF) begin
      entry_o.kind = failed_q ? KIND_LOAD_FAIL : KIND_LOAD_OK;
      entry_o.addr = 12'd0;
    end else begin
      entry_o.kind   = line_ok ? KIND_LINE_OK : KIND_LINE_BAD;
      entry_o.nbytes = (line_ok && data_line) ? n_q : '0;
      entry_o.line   = line_next;
    end
  end

  assign push_o = accept &&
                  ((action_i == ACT_EOL && !failed_q) || action_i == ACT_EOF);

  // Next state of line scan and load status
  always_comb begin
    col_d         = col_q;
    blank_d       = blank_q;
    hdr_bad_d     = hdr_bad_q;
    addr_d        = addr_q;
    run_d         = run_q;
    c7_blank_d    = c7_blank_q;
    pair_bad_d    = pair_bad_q;
    trail_bad_d   = trail_bad_q;
    tail8_bad_d   = tail8_bad_q;
    pipe_ok_d     = pipe_ok_q;
    n_d           = n_q;
    hi_d          = hi_q;
    bytes_d       = bytes_q;
    prior_d       = prior_q;
    prior_valid_d = prior_valid_q;
    failed_d      = failed_q;
    line_cnt_d    = line_cnt_q;

    if (accept) begin
      case (action_i)
        ACT_CHAR: begin
          if (col_q < ColW'(LineCols)) begin
            col_d = col_q + ColW'(1);
            // Comment line needs blanks in all columns before the bar
            if (col_q <= ColW'(LastBlankCol) && !is_space) begin
              blank_d = 1'b0;
            end
            // Header "0xHHH: "
            if (col_q == ColW'(0) && char_code_i != CH_ZERO) hdr_bad_d = 1'b1;
            if (col_q == ColW'(1) && char_code_i != CH_X)    hdr_bad_d = 1'b1;
            if (col_q >= ColW'(2) && col_q <= ColW'(4)) begin
              if (!is_hex) hdr_bad_d = 1'b1;
              addr_d = {addr_q[7:0], hex[3:0]};
            end
            if (col_q == ColW'(5) && char_code_i != CH_COLON) hdr_bad_d = 1'b1;
            if (col_q == ColW'(6) && !is_space)               hdr_bad_d = 1'b1;
            if (col_q == ColW'(DataCol) && is_space)          c7_blank_d = 1'b1;
            // Address-only line: blanks after the header
            if (col_q > ColW'(DataCol) && col_q <= ColW'(LastBlankCol) && !is_space) begin
              tail8_bad_d = 1'b1;
            end
            // Data run of hex pairs, then blanks
            if (col_q >= ColW'(DataCol) && col_q <= ColW'(LastBlankCol)) begin
              if (run_q) begin
                if (odd_col) begin
                  if (is_space) begin
                    run_d = 1'b0;
                  end else begin
                    if (!is_hex || col_q == ColW'(LastBlankCol)) pair_bad_d = 1'b1;
                    hi_d = hex[3:0];
                  end
                end else begin
                  if (!is_hex) begin
                    pair_bad_d = 1'b1;
                  end else if (n_q < NbyteW'(MaxBytes)) begin
                    bytes_d[n_q] = {hi_q, hex[3:0]};
                    n_d          = n_q + NbyteW'(1);
                  end
                end
              end else if (col_q < ColW'(LastBlankCol) && !is_space) begin
                trail_bad_d = 1'b1;
              end
            end
            if (col_q == ColW'(PipeCol)) pipe_ok_d = (char_code_i == CH_PIPE);
          end
        end
        ACT_EOL: begin
          line_cnt_d = line_next;
          if (!failed_q) begin
            if (!line_ok) begin
              failed_d = 1'b1;
            end else if (data_line) begin
              prior_d       = last_addr[11:0];
              prior_valid_d = 1'b1;
            end
          end
        end
        ACT_EOF: begin
          line_cnt_d    = 16'd0;
          failed_d      = 1'b0;
          prior_valid_d = 1'b0;
        end
        default: begin
        end
      endcase

      // Start a fresh line
      if (action_i == ACT_EOL || action_i == ACT_EOF) begin
        col_d       = '0;
        blank_d     = 1'b1;
        hdr_bad_d   = 1'b0;
        addr_d      = 12'd0;
        run_d       = 1'b1;
        c7_blank_d  = 1'b0;
        pair_bad_d  = 1'b0;
        trail_bad_d = 1'b0;
        tail8_bad_d = 1'b0;
        pipe_ok_d   = 1'b0;
        n_d         = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      blank_q       <= 1'b1;
      hdr_bad_q     <= 1'b0;
      addr_q        <= 12'd0;
      run_q         <= 1'b1;
      c7_blank_q    <= 1'b0;
      pair_bad_q    <= 1'b0;
      trail_bad_q   <= 1'b0;
      tail8_bad_q   <= 1'b0;
      pipe_ok_q     <= 1'b0;
      n_q           <= '0;
      prior_q       <= 12'd0;
      prior_valid_q <= 1'b0;
      failed_q      <= 1'b0;
      line_cnt_q    <= 16'd0;
    end else begin
      col_q         <= col_d;
      blank_q       <= blank_d;
      hdr_bad_q     <= hdr_bad_d;
      addr_q        <= addr_d;
      run_q         <= run_d;
      c7_blank_q    <= c7_blank_d;
      pair_bad_q    <= pair_bad_d;
      trail_bad_q   <= trail_bad_d;
      tail8_bad_q   <= tail8_bad_d;
      pipe_ok_q     <= pipe_ok_d;
      n_q           <= n_d;
      prior_q       <= prior_d;
      prior_valid_q <= prior_valid_d;
      failed_q      <= failed_d;
      line_cnt_q    <= line_cnt_d;
    end
  end

  // Hold decoded bytes and pending high nibble
  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    bytes_q <= bytes_d;
  end

endmodule

>>> rtl/otll_queue.sv
// Short request queue between the line classifier and the result emitter.
module otll_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  otll_pkg::line_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output otll_pkg::line_entry_t head_o
);
  import otll_pkg::*;

  line_entry_t            slots_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QueuePtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QueuePtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("queue pop while empty");
`endif

endmodule

>>> rtl/otll_back.sv
// Back end: expands queued requests into memory writes and a status, one per unstalled cycle.
module otll_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  otll_pkg::line_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            kind_o,
  output logic [11:0]           mem_address_o,
  output logic [7:0]            mem_byte_o,
  output logic [15:0]           line_number_o,
  output logic                  last_of_run_o
);
  import otll_pkg::*;

  nbyte_t      idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  kind_q, kind_d;
  logic [11:0] addr_q, addr_d;
  logic [7:0]  byte_q, byte_d;
  logic [15:0] line_q, line_d;
  logic        last_q, last_d;

  logic out_free;
  logic emit;
  logic more;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = !empty_i && out_free;
  assign more     = idx_q < head_i.nbytes;
  assign pop_o    = emit && !more;

  // Pick the next result of the head request
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    addr_d      = addr_q;
    byte_d      = byte_q;
    line_d      = line_q;
    last_d      = last_q;
    if (out_free) begin
      out_valid_d = emit;
    end
    if (emit) begin
      if (more) begin
        kind_d = KIND_WRITE;
        addr_d = 12'(head_i.addr + 12'(idx_q));
        byte_d = head_i.data[idx_q];
        line_d = 16'd0;
        last_d = 1'b0;
        idx_d  = idx_q + NbyteW'(1);
      end else begin
        kind_d = head_i.kind;
        addr_d = 12'd0;
        byte_d = 8'd0;
        line_d = head_i.line;
        last_d = 1'b1;
        idx_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    byte_q <= byte_d;
    line_q <= line_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign mem_address_o = addr_q;
  assign mem_byte_o    = byte_q;
  assign line_number_o = line_q;
  assign last_of_run_o = last_q;

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q <= head_i.nbytes)
    else $error("byte index past request length");

  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_WRITE) |-> !last_q)
    else $error("memory write flagged as last of run");

  a_pop_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0)
    else $error("byte index not cleared after request done");
`endif

endmodule

>>> rtl/object_text_line_loader_unit.sv
// Top level of the object text line loader: classifier, line queue and result emitter.
// One character, end of line or end of file is taken per clock. Each line is checked
// column by column as it arrives, so its verdict is ready on the end-of-line cycle and
// goes into a two-entry request queue. The emitter then drains one result per cycle,
// unless the output stalls, through the output register: a data line of n bytes gives
// n memory writes and one status result, at most eleven results per line, while the next
// line's characters keep arriving. Input stalls only while the request queue is full,
// that is with a request waiting behind one whose burst is still draining: an end of file
// or a short line soon after a data line, or requests piling up behind a stalled output.
module object_text_line_loader_unit #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [11:0] mem_address_o,
  output logic [7:0]  mem_byte_o,
  output logic [15:0] line_number_o,
  output logic        last_of_run_o
);
  import otll_pkg::*;

  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  line_entry_t entry;
  line_entry_t head;

  otll_front #(
    .MEM_BYTES(MEM_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .char_code_i (char_code_i),
    .push_o      (push),
    .entry_o     (entry),
    .full_i      (full)
  );

  otll_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  otll_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .mem_address_o (mem_address_o),
    .mem_byte_o    (mem_byte_o),
    .line_number_o (line_number_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
